FILE: hw/rtl/ptc_pkg.sv
// Shared types, constants and helpers for the pressure/temperature compensation pipeline.
`default_nettype none
package ptc_pkg;

  localparam int unsigned DivWidth = 32;
  localparam int unsigned AddrWidth = 5;
  localparam int unsigned DataWidth = 64;
  localparam int unsigned CoefWidth = 48;

  localparam logic [31:0] TempOffset  = 32'd64000;
  localparam logic [31:0] PressBase   = 32'd1048576;
  localparam logic [31:0] PressScale  = 32'd3125;
  localparam logic [31:0] SignBit     = 32'h8000_0000;
  localparam logic [31:0] UnityGain   = 32'd32768;
  localparam logic [31:0] RoundHalf   = 32'd128;

  typedef enum logic [1:0] {
    REG_TEMP    = 2'd0,
    REG_PRESS_A = 2'd1,
    REG_PRESS_B = 2'd2,
    REG_PRESS_C = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [19:0] raw_temp;
    logic [19:0] raw_press;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] temp_centi;
    logic [31:0]        press_pa;
    logic               div_zero;
  } out_res_t;

  // Calibration words, already extended to 32 bits.
  typedef struct packed {
    logic [31:0] t1, t2, t3;
    logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  } coef_t;

  // Data that rides alongside the divider.
  typedef struct packed {
    logic [31:0] temp;
    logic        dz;
    logic        dbl;
  } div_side_t;

  function automatic logic [31:0] sx16(input logic [15:0] w);
    return {{16{w[15]}}, w};
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
    return 32'($signed(x) >>> n);
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/ptc_temp.sv
// Fine temperature stages: raw reading to fine term, centi-degrees and first pressure term.
`default_nettype none
module ptc_temp (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           valid_i,
  input  wire ptc_pkg::in_req_t req_i,
  input  wire ptc_pkg::coef_t coef_i,
  output logic                valid_o,
  output logic [31:0]         temp_o,
  output logic [31:0]         v1_o,
  output logic [19:0]         adc_p_o
);
  import ptc_pkg::*;

  logic [4:0]  vld_q;
  logic [31:0] x_q, d_q, m1_q, dd_q, a_q, m2_q, tf_q, temp_q, v1_q;
  logic [19:0] ap1_q, ap2_q, ap3_q, ap4_q, ap5_q;
  logic [31:0] adc_t;

  assign adc_t = {12'd0, req_i.raw_temp};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= (adc_t >> 3) - (coef_i.t1 << 1);
      d_q    <= (adc_t >> 4) - coef_i.t1;
      ap1_q  <= req_i.raw_press;
      m1_q   <= x_q * coef_i.t2;
      dd_q   <= d_q * d_q;
      ap2_q  <= ap1_q;
      a_q    <= asr(m1_q, 11);
      m2_q   <= asr(dd_q, 12) * coef_i.t3;
      ap3_q  <= ap2_q;
      tf_q   <= a_q + asr(m2_q, 14);
      ap4_q  <= ap3_q;
      // tf*5 as shift-and-add
      temp_q <= asr((tf_q << 2) + tf_q + RoundHalf, 8);
      v1_q   <= asr(tf_q, 1) - TempOffset;
      ap5_q  <= ap4_q;
    end
  end

  assign valid_o = vld_q[4];
  assign temp_o  = temp_q;
  assign v1_o    = v1_q;
  assign adc_p_o = ap5_q;
endmodule
`default_nettype wire

FILE: hw/rtl/ptc_press.sv
// Pressure pre-division stages: offset, gain and dividend for the divider.
`default_nettype none
module ptc_press (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             valid_i,
  input  wire logic [31:0]      temp_i,
  input  wire logic [31:0]      v1_i,
  input  wire logic [19:0]      adc_p_i,
  input  wire ptc_pkg::coef_t   coef_i,
  output logic                  valid_o,
  output logic [31:0]           num_o,
  output logic [31:0]           den_o,
  output ptc_pkg::div_side_t    side_o
);
  import ptc_pkg::*;

  logic [5:0]  vld_q;
  logic [31:0] t6_q, t7_q, t8_q, t9_q, t10_q;
  logic [19:0] ap6_q, ap7_q, ap8_q;
  logic [31:0] q6_q, m5_q, mb6_q, m5b_q, mb7_q, v2a_q, m3_q;
  logic [31:0] v2_q, v1b_q, w_q, pn_q, v1c_q, pm_q;
  logic [31:0] qa, q11, v1sum;
  div_side_t   side_q;
  logic [31:0] num_q, den_q;

  assign qa    = asr(v1_i, 2);
  assign v1sum = UnityGain + v1b_q;
  assign q11   = asr(q6_q, 11);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // stage 6
      q6_q  <= qa * qa;
      m5_q  <= v1_i * coef_i.p5;
      mb6_q <= coef_i.p2 * v1_i;
      t6_q  <= temp_i;
      ap6_q <= adc_p_i;
      // stage 7
      v2a_q <= q11 * coef_i.p6;
      m3_q  <= coef_i.p3 * asr(q6_q, 13);
      m5b_q <= m5_q;
      mb7_q <= mb6_q;
      t7_q  <= t6_q;
      ap7_q <= ap6_q;
      // stage 8
      v2_q  <= asr(v2a_q + (m5b_q << 1), 2) + (coef_i.p4 << 16);
      v1b_q <= asr(asr(m3_q, 3) + asr(mb7_q, 1), 18);
      t8_q  <= t7_q;
      ap8_q <= ap7_q;
      // stage 9
      w_q   <= v1sum * coef_i.p1;
      pn_q  <= (PressBase - {12'd0, ap8_q}) - asr(v2_q, 12);
      t9_q  <= t8_q;
      // stage 10
      v1c_q <= asr(w_q, 15);
      pm_q  <= pn_q * PressScale;
      t10_q <= t9_q;
      // stage 11: dividend doubled before or after the divide
      den_q       <= v1c_q;
      side_q.temp <= t10_q;
      side_q.dz   <= (v1c_q == '0);
      if (pm_q < SignBit) begin
        num_q      <= pm_q << 1;
        side_q.dbl <= 1'b0;
      end else begin
        num_q      <= pm_q;
        side_q.dbl <= 1'b1;
      end
    end
  end

  assign valid_o = vld_q[5];
  assign num_o   = num_q;
  assign den_o   = den_q;
  assign side_o  = side_q;
endmodule
`default_nettype wire

FILE: hw/rtl/ptc_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
`default_nettype none
module ptc_div #(
  parameter int unsigned Width = ptc_pkg::DivWidth
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               valid_i,
  input  wire logic [Width-1:0]   num_i,
  input  wire logic [Width-1:0]   den_i,
  input  wire ptc_pkg::div_side_t side_i,
  output logic                    valid_o,
  output logic [Width-1:0]        quo_o,
  output ptc_pkg::div_side_t      side_o
);
  import ptc_pkg::*;

  logic [Width-1:0] vld_q;
  logic [Width-1:0] num_q  [Width];
  logic [Width-1:0] den_q  [Width];
  logic [Width-1:0] quo_q  [Width];
  logic [Width-1:0] rem_q  [Width];
  div_side_t        side_q [Width];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Width-2:0], valid_i};
    end
  end

  for (genvar k = 0; k < Width; k++) begin : g_stage
    logic [Width-1:0] num_in, den_in, quo_in, rem_in;
    div_side_t        side_in;
    logic [Width:0]   trial, diff;

    if (k == 0) begin : g_first
      assign num_in  = num_i;
      assign den_in  = den_i;
      assign quo_in  = '0;
      assign rem_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign num_in  = num_q[k-1];
      assign den_in  = den_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign trial = {rem_in, num_in[Width-1-k]};
    assign diff  = trial - {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[k]  <= num_in;
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
        if (!diff[Width]) begin
          rem_q[k] <= diff[Width-1:0];
          quo_q[k] <= quo_in | (Width'(1) << (Width-1-k));
        end else begin
          rem_q[k] <= trial[Width-1:0];
          quo_q[k] <= quo_in;
        end
      end
    end
  end

  assign valid_o = vld_q[Width-1];
  assign quo_o   = quo_q[Width-1];
  assign side_o  = side_q[Width-1];
endmodule
`default_nettype wire

FILE: hw/rtl/ptc_post.sv
// Post-division stages: nonlinear pressure correction and output register.
`default_nettype none
module ptc_post (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               valid_i,
  input  wire logic [31:0]        quo_i,
  input  wire ptc_pkg::div_side_t side_i,
  input  wire ptc_pkg::coef_t     coef_i,
  output logic                    valid_o,
  output ptc_pkg::out_res_t       res_o
);
  import ptc_pkg::*;

  logic [2:0]  vld_q;
  logic [31:0] p, pa;
  logic [31:0] p1_q, pb_q, m8_q, p2_q, m9_q, m8b_q, t1_q, t2_q;
  logic        dz1_q, dz2_q;
  logic [31:0] corr;
  out_res_t    res_q;

  assign p    = side_i.dbl ? (quo_i << 1) : quo_i;
  assign pa   = p >> 3;
  assign corr = asr(asr(m9_q, 12) + asr(m8b_q, 13) + coef_i.p7, 4);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q  <= p;
      pb_q  <= pa * pa;
      m8_q  <= (p >> 2) * coef_i.p8;
      t1_q  <= side_i.temp;
      dz1_q <= side_i.dz;
      m9_q  <= coef_i.p9 * (pb_q >> 13);
      m8b_q <= m8_q;
      p2_q  <= p1_q;
      t2_q  <= t1_q;
      dz2_q <= dz1_q;
      res_q.temp_centi <= $signed(t2_q);
      res_q.press_pa   <= dz2_q ? '0 : p2_q + corr;
      res_q.div_zero   <= dz2_q;
    end
  end

  assign valid_o = vld_q[2];
  assign res_o   = res_q;
endmodule
`default_nettype wire

FILE: hw/rtl/pressure_temperature_compensation.sv
// Top level: calibration registers and the full compensation pipeline.
`default_nettype none
// Channel   Direction  Handshake               Payload
// in        sink       in_valid_i / in_stall_o  in_req_i  (raw_temp, raw_press)
// out       source     out_valid_o / out_stall_i out_res_o (temp_centi, press_pa, div_zero)
// apb       sink       psel/penable/pready      paddr, pwdata, prdata
//
// One request enters per cycle unless in_stall_o is high; the path runs temp, press, divider, post.
// The divider dominates depth: one quotient bit per stage.
// All stages advance together; a stalled result freezes the whole pipe, so nothing
// is lost or repeated. While out_stall_i is high with a result pending, the pipe
// holds as one block and in_stall_o is raised.
// Reset clears valid bits and calibration registers; payload registers are not reset.
module pressure_temperature_compensation (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire ptc_pkg::in_req_t                   in_req_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output ptc_pkg::out_res_t                       out_res_o,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [ptc_pkg::AddrWidth-1:0]      paddr,
  input  wire logic [ptc_pkg::DataWidth-1:0]      pwdata,
  output logic [ptc_pkg::DataWidth-1:0]           prdata,
  output logic                                    pready
);
  import ptc_pkg::*;

  logic [CoefWidth-1:0] temp_coeffs_q, press_a_q, press_b_q, press_c_q;
  reg_idx_e             widx;
  logic                 en;
  coef_t                coef;

  // register index sits above the 8-byte word offset
  assign widx   = reg_idx_e'(paddr[AddrWidth-1:3]);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_coeffs_q <= '0;
      press_a_q     <= '0;
      press_b_q     <= '0;
      press_c_q     <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (widx)
        REG_TEMP:    temp_coeffs_q <= pwdata[CoefWidth-1:0];
        REG_PRESS_A: press_a_q     <= pwdata[CoefWidth-1:0];
        REG_PRESS_B: press_b_q     <= pwdata[CoefWidth-1:0];
        REG_PRESS_C: press_c_q     <= pwdata[CoefWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_TEMP:    prdata = {{(DataWidth-CoefWidth){1'b0}}, temp_coeffs_q};
      REG_PRESS_A: prdata = {{(DataWidth-CoefWidth){1'b0}}, press_a_q};
      REG_PRESS_B: prdata = {{(DataWidth-CoefWidth){1'b0}}, press_b_q};
      REG_PRESS_C: prdata = {{(DataWidth-CoefWidth){1'b0}}, press_c_q};
      default:     prdata = '0;
    endcase
  end

  // unpack calibration words
  assign coef.t1 = {16'd0, temp_coeffs_q[15:0]};
  assign coef.t2 = sx16(temp_coeffs_q[31:16]);
  assign coef.t3 = sx16(temp_coeffs_q[47:32]);
  assign coef.p1 = {16'd0, press_a_q[15:0]};
  assign coef.p2 = sx16(press_a_q[31:16]);
  assign coef.p3 = sx16(press_a_q[47:32]);
  assign coef.p4 = sx16(press_b_q[15:0]);
  assign coef.p5 = sx16(press_b_q[31:16]);
  assign coef.p6 = sx16(press_b_q[47:32]);
  assign coef.p7 = sx16(press_c_q[15:0]);
  assign coef.p8 = sx16(press_c_q[31:16]);
  assign coef.p9 = sx16(press_c_q[47:32]);

  // whole pipe moves unless a finished result is held back
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  logic        tv;
  logic [31:0] t_temp, t_v1;
  logic [19:0] t_adcp;
  logic        pv;
  logic [31:0] p_num, p_den;
  div_side_t   p_side;
  logic        dv;
  logic [31:0] d_quo;
  div_side_t   d_side;

  ptc_temp u_temp (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i), .req_i(in_req_i),
    .coef_i(coef), .valid_o(tv), .temp_o(t_temp), .v1_o(t_v1), .adc_p_o(t_adcp)
  );

  ptc_press u_press (
    .clk_i, .rst_ni, .en_i(en), .valid_i(tv), .temp_i(t_temp), .v1_i(t_v1),
    .adc_p_i(t_adcp), .coef_i(coef), .valid_o(pv), .num_o(p_num), .den_o(p_den),
    .side_o(p_side)
  );

  ptc_div #(.Width(DivWidth)) u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(pv), .num_i(p_num[DivWidth-1:0]),
    .den_i(p_den[DivWidth-1:0]), .side_i(p_side), .valid_o(dv), .quo_o(d_quo),
    .side_o(d_side)
  );

  ptc_post u_post (
    .clk_i, .rst_ni, .en_i(en), .valid_i(dv), .quo_i(d_quo), .side_i(d_side),
    .coef_i(coef), .valid_o(out_valid_o), .res_o(out_res_o)
  );
endmodule
`default_nettype wire
